/* sv/assert_macros.svh */
// Assertion macros used by the top level of the PTZ frame encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/ptzenc_pkg.sv */
// Types, codes and constants of the PTZ command frame encoder.
package ptzenc_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] OP_PANTILT       = 3'd0;
  localparam logic [2:0] OP_STOP          = 3'd1;
  localparam logic [2:0] OP_HOME          = 3'd2;
  localparam logic [2:0] OP_ZOOM_IN       = 3'd3;
  localparam logic [2:0] OP_ZOOM_OUT      = 3'd4;
  localparam logic [2:0] OP_PRESET_SET    = 3'd5;
  localparam logic [2:0] OP_PRESET_CLEAR  = 3'd6;
  localparam logic [2:0] OP_PRESET_RECALL = 3'd7;

  localparam logic [7:0] SYNC_BYTE       = 8'hFF;
  localparam logic [7:0] CMD_NONE        = 8'h00;
  localparam logic [7:0] CMD_HOME        = 8'h07;
  localparam logic [7:0] DATA_HOME       = 8'h2B;
  localparam logic [7:0] CMD_ZOOM_SPEED  = 8'h25;
  localparam logic [7:0] CMD_ZOOM_IN     = 8'h20;
  localparam logic [7:0] CMD_ZOOM_OUT    = 8'h40;
  localparam logic [7:0] CMD_PRESET_SET  = 8'h03;
  localparam logic [7:0] CMD_PRESET_CLR  = 8'h05;
  localparam logic [7:0] CMD_PRESET_CALL = 8'h07;
  localparam logic [7:0] DIR_TILT_DOWN   = 8'h10;
  localparam logic [7:0] DIR_TILT_UP     = 8'h08;
  localparam logic [7:0] DIR_PAN_LEFT    = 8'h04;
  localparam logic [7:0] DIR_PAN_RIGHT   = 8'h02;

  localparam logic [16:0] DEAD_ZONE_RAW  = 17'd164;
  localparam logic [5:0]  PT_SPEED_MAX   = 6'd63;
  localparam logic [5:0]  ZOOM_SPEED_MAX = 6'd51;

  // Byte positions within a 7-byte frame.
  localparam logic [2:0] IDX_SYNC  = 3'd0;
  localparam logic [2:0] IDX_ADDR  = 3'd1;
  localparam logic [2:0] IDX_CMD1  = 3'd2;
  localparam logic [2:0] IDX_CMD2  = 3'd3;
  localparam logic [2:0] IDX_DATA1 = 3'd4;
  localparam logic [2:0] IDX_DATA2 = 3'd5;
  localparam logic [2:0] IDX_SUM   = 3'd6;

  localparam logic REG_DEVICE_ADDRESS = 1'b0;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] pan_rate;
    logic signed [15:0] tilt_rate;
    logic signed [15:0] zoom_rate;
    logic [7:0]         preset_number;
  } cmd_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       last_of_run;
  } result_t;

  // One frame as queued between front and back; command byte 1 is always zero.
  typedef struct packed {
    logic [7:0] cmd2;
    logic [7:0] data1;
    logic [7:0] data2;
    logic       last;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* sv/ptzenc_front.sv */
// Front end: takes commands, classifies them and queues their frame descriptors.
module ptzenc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  ptzenc_pkg::cmd_t      cmd,
  input  ptzenc_pkg::q_status_t q_stat,
  output logic                  q_push,
  output ptzenc_pkg::frame_t    q_frame
);

  logic             hold_valid;
  ptzenc_pkg::cmd_t hold;
  logic             phase;

  logic [16:0] pan_mag;
  logic [16:0] tilt_mag;
  logic [16:0] zoom_mag;
  logic [7:0]  dir;
  logic [7:0]  preset_next;
  logic        reject;
  logic        done_now;
  logic        accept;

  function automatic logic [16:0] magnitude(input logic [15:0] r);
    return r[15] ? (17'h0 - {1'b1, r}) : {1'b0, r};
  endfunction

  function automatic logic [7:0] scale(input logic [16:0] mag, input logic [5:0] k);
    logic [22:0] prod;
    prod = 23'(mag) * 23'(k);
    return prod[22:15];
  endfunction

  always_comb begin
    pan_mag     = magnitude(hold.pan_rate);
    tilt_mag    = magnitude(hold.tilt_rate);
    zoom_mag    = magnitude(hold.zoom_rate);
    preset_next = hold.preset_number + 8'd1;
    dir         = 8'h00;
    if (tilt_mag >= ptzenc_pkg::DEAD_ZONE_RAW) begin
      dir = dir | (hold.tilt_rate[15] ? ptzenc_pkg::DIR_TILT_DOWN : ptzenc_pkg::DIR_TILT_UP);
    end
    if (pan_mag >= ptzenc_pkg::DEAD_ZONE_RAW) begin
      dir = dir | (hold.pan_rate[15] ? ptzenc_pkg::DIR_PAN_LEFT : ptzenc_pkg::DIR_PAN_RIGHT);
    end

    reject        = 1'b0;
    q_frame.cmd2  = ptzenc_pkg::CMD_NONE;
    q_frame.data1 = 8'h00;
    q_frame.data2 = 8'h00;
    q_frame.last  = 1'b1;
    case (hold.op)
      ptzenc_pkg::OP_PANTILT: begin
        q_frame.cmd2  = dir;
        q_frame.data1 = scale(pan_mag, ptzenc_pkg::PT_SPEED_MAX);
        q_frame.data2 = scale(tilt_mag, ptzenc_pkg::PT_SPEED_MAX);
      end
      ptzenc_pkg::OP_STOP: begin
        q_frame.cmd2 = ptzenc_pkg::CMD_NONE;
      end
      ptzenc_pkg::OP_HOME: begin
        q_frame.cmd2  = ptzenc_pkg::CMD_HOME;
        q_frame.data2 = ptzenc_pkg::DATA_HOME;
      end
      ptzenc_pkg::OP_ZOOM_IN, ptzenc_pkg::OP_ZOOM_OUT: begin
        // A zoom command first sends the zoom-speed frame, then the move frame.
        if (!phase) begin
          q_frame.cmd2  = ptzenc_pkg::CMD_ZOOM_SPEED;
          q_frame.data2 = scale(zoom_mag, ptzenc_pkg::ZOOM_SPEED_MAX);
          q_frame.last  = 1'b0;
        end else begin
          q_frame.cmd2 = (hold.op == ptzenc_pkg::OP_ZOOM_IN) ?
                         ptzenc_pkg::CMD_ZOOM_IN : ptzenc_pkg::CMD_ZOOM_OUT;
        end
      end
      ptzenc_pkg::OP_PRESET_SET: begin
        reject        = (hold.preset_number == 8'd0);
        q_frame.cmd2  = ptzenc_pkg::CMD_PRESET_SET;
        q_frame.data2 = preset_next;
      end
      ptzenc_pkg::OP_PRESET_CLEAR: begin
        reject        = (hold.preset_number == 8'd0);
        q_frame.cmd2  = ptzenc_pkg::CMD_PRESET_CLR;
        q_frame.data2 = preset_next;
      end
      default: begin
        q_frame.cmd2  = ptzenc_pkg::CMD_PRESET_CALL;
        q_frame.data2 = preset_next;
      end
    endcase

    q_push   = hold_valid && !reject && !q_stat.full;
    done_now = hold_valid && (reject || (!q_stat.full && q_frame.last));
    busy     = hold_valid && !done_now;
    accept   = start && !busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      phase      <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
      phase      <= 1'b0;
    end else if (done_now) begin
      hold_valid <= 1'b0;
    end else if (q_push) begin
      phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= cmd;
    end
  end

endmodule

/* sv/ptzenc_queue.sv */
// Small frame descriptor queue between the front and back ends.
module ptzenc_queue #(
  parameter int DEPTH = ptzenc_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ptzenc_pkg::frame_t    push_frame,
  input  logic                  pop,
  output ptzenc_pkg::frame_t    head,
  output ptzenc_pkg::q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ptzenc_pkg::frame_t entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head         = entries[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= advance(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= advance(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

endmodule

/* sv/ptzenc_back.sv */
// Back end: serializes queued frames into bytes with address and checksum.
module ptzenc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            device_address,
  input  ptzenc_pkg::q_status_t q_stat,
  input  ptzenc_pkg::frame_t    head,
  output logic                  q_pop,
  output logic                  result_strobe,
  output ptzenc_pkg::result_t   result
);

  logic               active;
  logic [2:0]         idx;
  ptzenc_pkg::frame_t cur;
  logic [7:0]         byte_now;
  logic [7:0]         checksum;
  logic               at_end;

  always_comb begin
    checksum = device_address + cur.cmd2 + cur.data1 + cur.data2;
    at_end   = (idx == ptzenc_pkg::IDX_SUM);
    case (idx)
      ptzenc_pkg::IDX_SYNC:  byte_now = ptzenc_pkg::SYNC_BYTE;
      ptzenc_pkg::IDX_ADDR:  byte_now = device_address;
      ptzenc_pkg::IDX_CMD1:  byte_now = ptzenc_pkg::CMD_NONE;
      ptzenc_pkg::IDX_CMD2:  byte_now = cur.cmd2;
      ptzenc_pkg::IDX_DATA1: byte_now = cur.data1;
      ptzenc_pkg::IDX_DATA2: byte_now = cur.data2;
      default:               byte_now = checksum;
    endcase
    // The next frame is loaded as the current one sends its checksum.
    q_pop = !q_stat.empty && (!active || at_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      idx           <= ptzenc_pkg::IDX_SYNC;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= active;
      if (q_pop) begin
        active <= 1'b1;
        idx    <= ptzenc_pkg::IDX_SYNC;
      end else if (active) begin
        if (at_end) begin
          active <= 1'b0;
        end else begin
          idx <= idx + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= head;
    end
    result.frame_byte  <= byte_now;
    result.frame_end   <= at_end;
    result.last_of_run <= at_end && cur.last;
  end

endmodule

/* sv/ptz_command_frame_encoder_unit.sv */
// Top level of the PTZ command frame encoder with its configuration port.
// A command is taken on cmd at a clock edge with start high and busy low.
// It becomes one 7-byte frame (sync, address, two command bytes, two data
// bytes, checksum), or two frames for a zoom command, and nothing for a
// preset set or clear with preset zero. Bytes leave on result, one per
// cycle, each marked by result_strobe for exactly one cycle; frame_end marks
// the checksum byte and last_of_run the final byte of the command.
// When the serializer is idle, the first byte of a command passes through the
// front command register, the queue, the serializer frame register and the
// result register. The serializer emits one byte per cycle while it sends a
// frame, and frames follow with no gap while the queue holds another. Commands
// are classified in a front stage and wait as frame descriptors in a small
// queue, so a new command is taken while earlier frames are still being sent.
// busy is high while a command waits on a full queue, and while the first
// frame of a taken zoom command is queued.
// The receiver cannot stall and every byte is sent as it is formed.
// The device address register lies at byte address 0 of the APB port and
// resets to 1; reset also empties the queue and drops any command in flight.
`include "assert_macros.svh"
module ptz_command_frame_encoder_unit #(
  parameter int QUEUE_DEPTH = ptzenc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ptzenc_pkg::cmd_t    cmd,
  output logic                result_strobe,
  output ptzenc_pkg::result_t result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [0:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [7:0]            device_address;
  logic                  q_push;
  logic                  q_pop;
  ptzenc_pkg::frame_t    q_in;
  ptzenc_pkg::frame_t    q_head;
  ptzenc_pkg::q_status_t q_stat;
  logic                  first_is_sync;

  assign pready = 1'b1;
  assign prdata = (paddr == ptzenc_pkg::REG_DEVICE_ADDRESS) ? {24'h0, device_address} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'd1;
    end else if (psel && penable && pwrite && pready &&
                 paddr == ptzenc_pkg::REG_DEVICE_ADDRESS) begin
      device_address <= pwdata[7:0];
    end
  end

  ptzenc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_frame (q_in)
  );

  ptzenc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_frame (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_stat)
  );

  ptzenc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .device_address (device_address),
    .q_stat         (q_stat),
    .head           (q_head),
    .q_pop          (q_pop),
    .result_strobe  (result_strobe),
    .result         (result)
  );

  assign first_is_sync = result_strobe && (result.frame_byte == ptzenc_pkg::SYNC_BYTE);

  `ASSERT_IMPLY(a_no_push_full, clk, rst, q_push, !q_stat.full)
  `ASSERT_IMPLY(a_no_pop_empty, clk, rst, q_pop, !q_stat.empty)
  `ASSERT_NEXT(a_pop_starts_sync, clk, rst, q_pop, ##1 first_is_sync)

endmodule
